>>> hw/rtl/iasq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iasq_pkg
// Shared types and constants of the interlocked actuator sequencer.
// ----------------------------------------------------------------------------
package iasq_pkg;

    localparam int POS_BITS_DEF = 16;

    localparam int DT_W    = 10;
    localparam int SPEED_W = 16;
    localparam int DA_W    = DT_W + SPEED_W;
    localparam int PH_W    = 3;
    localparam int OUT_W   = 16;
    localparam int TB_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    // Actuator phases.
    localparam logic [PH_W-1:0] PH_CLOSED  = 3'd0;
    localparam logic [PH_W-1:0] PH_OPEN    = 3'd1;
    localparam logic [PH_W-1:0] PH_CLOSING = 3'd2;
    localparam logic [PH_W-1:0] PH_OPENING = 3'd3;
    localparam logic [PH_W-1:0] PH_STOPPED = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DOOR_SPEED       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOOR_LATCH_SPEED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAD_LATCH_SPEED  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIATOR_SPEED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANTENNA_SPEED    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_ANTENNA      = 3'd5;

    // Talkback bit positions.
    localparam int TB_DOOR_OPEN     = 0;
    localparam int TB_DOOR_CLOSED   = 1;
    localparam int TB_LATCH_LATCHED = 2;
    localparam int TB_LATCH_RELEASE = 3;
    localparam int TB_RAD_STOWED    = 4;
    localparam int TB_RAD_DEPLOYED  = 5;
    localparam int TB_ANT_STOWED    = 6;
    localparam int TB_ANT_DEPLOYED  = 7;

    // Output position slots.
    localparam int NUM_POS     = 6;
    localparam int SLOT_DOOR   = 0;
    localparam int SLOT_LATCHA = 1;
    localparam int SLOT_LATCHB = 2;
    localparam int SLOT_RLATCH = 3;
    localparam int SLOT_RAD    = 4;
    localparam int SLOT_ANT    = 5;

    // One decoded tick: step sizes and command conditions.
    typedef struct packed {
        logic [DA_W-1:0] da_door;
        logic [DA_W-1:0] da_dlatch;
        logic [DA_W-1:0] da_rlatch;
        logic [DA_W-1:0] da_rad;
        logic [DA_W-1:0] da_ant;
        logic            door_en;
        logic            door_close;
        logic            door_open;
        logic            power_ok;
        logic            rl_close;
        logic            rl_open;
        logic            rad_stow;
        logic            rad_deploy;
        logic            ant_stow;
        logic            ant_deploy;
    } t_step;

endpackage

>>> hw/rtl/iasq_input_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iasq_input_stage
// Input register: forms the step sizes and decodes the command bits of an item.
// ----------------------------------------------------------------------------
module iasq_input_stage import iasq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic [DT_W-1:0]    i_delta_t,
    input  logic [1:0]         i_door_enable,
    input  logic               i_door_close,
    input  logic               i_door_open,
    input  logic [1:0]         i_mech_power,
    input  logic [1:0]         i_latch_cmd,
    input  logic [1:0]         i_release_cmd,
    input  logic [1:0]         i_stow_cmd,
    input  logic [1:0]         i_deploy_cmd,
    input  logic [1:0]         i_ku_stow,
    input  logic               i_ku_deploy,
    input  logic [SPEED_W-1:0] i_door_speed,
    input  logic [SPEED_W-1:0] i_door_latch_speed,
    input  logic [SPEED_W-1:0] i_rad_latch_speed,
    input  logic [SPEED_W-1:0] i_radiator_speed,
    input  logic [SPEED_W-1:0] i_antenna_speed,
    output t_step              o_step
);

    t_step           r_step;
    t_step           n_step;
    logic [DA_W-1:0] w_rl_full;
    logic [DA_W-1:0] w_rad_full;

    always_comb begin
        w_rl_full  = DA_W'(i_delta_t) * DA_W'(i_rad_latch_speed);
        w_rad_full = DA_W'(i_delta_t) * DA_W'(i_radiator_speed);

        n_step.da_door   = DA_W'(i_delta_t) * DA_W'(i_door_speed);
        n_step.da_dlatch = DA_W'(i_delta_t) * DA_W'(i_door_latch_speed);
        n_step.da_ant    = DA_W'(i_delta_t) * DA_W'(i_antenna_speed);
        // A single latch or stow motor drives at half speed.
        n_step.da_rlatch = (^i_latch_cmd) ? (w_rl_full >> 1) : w_rl_full;
        n_step.da_rad    = (^i_stow_cmd) ? (w_rad_full >> 1) : w_rad_full;

        n_step.door_en    = &i_door_enable;
        n_step.door_close = i_door_close;
        n_step.door_open  = i_door_open;
        n_step.power_ok   = &i_mech_power;
        n_step.rl_close   = (|i_latch_cmd) & ~(|i_release_cmd);
        n_step.rl_open    = (|i_release_cmd) & ~(|i_latch_cmd);
        n_step.rad_stow   = (|i_stow_cmd) & ~(|i_deploy_cmd);
        n_step.rad_deploy = (|i_deploy_cmd) & ~(|i_stow_cmd);
        n_step.ant_stow   = |i_ku_stow;
        n_step.ant_deploy = i_ku_deploy;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_step <= n_step;
        end
    end

    assign o_step = r_step;

endmodule

>>> hw/rtl/iasq_motion_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iasq_motion_core
// Actuator state: positions and phases, updated once per item with interlocks.
// ----------------------------------------------------------------------------
module iasq_motion_core import iasq_pkg::*; #(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  t_step            i_step,
    input  logic             i_has_antenna,
    output logic [OUT_W-1:0] o_pos16 [NUM_POS],
    output logic [TB_W-1:0]  o_talkbacks
);

    localparam int CW = (POS_BITS > DA_W) ? POS_BITS : DA_W;
    localparam int RW = PH_W + POS_BITS;

    logic [POS_BITS-1:0] r_pos [NUM_POS];
    logic [POS_BITS-1:0] n_pos [NUM_POS];
    logic [PH_W-1:0]     r_ph  [NUM_POS];
    logic [PH_W-1:0]     n_ph  [NUM_POS];
    logic [RW-1:0]       w_res;

    function automatic logic [RW-1:0] f_close(input logic [POS_BITS-1:0] pos,
                                              input logic [DA_W-1:0] da);
        logic [CW-1:0]       pe;
        logic [CW-1:0]       de;
        logic [POS_BITS-1:0] np;
        logic [PH_W-1:0]     ph;
        pe = CW'(pos);
        de = CW'(da);
        if (pos != '0) begin
            ph = PH_CLOSING;
            np = (pe > de) ? POS_BITS'(pe - de) : '0;
        end else begin
            ph = PH_CLOSED;
            np = pos;
        end
        return {ph, np};
    endfunction

    function automatic logic [RW-1:0] f_open(input logic [POS_BITS-1:0] pos,
                                             input logic [DA_W-1:0] da);
        logic [CW-1:0]       pe;
        logic [CW-1:0]       de;
        logic [CW-1:0]       rem;
        logic [POS_BITS-1:0] full;
        logic [POS_BITS-1:0] np;
        logic [PH_W-1:0]     ph;
        full = '1;
        pe   = CW'(pos);
        de   = CW'(da);
        rem  = CW'(full - pos);
        if (pos != full) begin
            ph = PH_OPENING;
            np = (rem > de) ? POS_BITS'(pe + de) : full;
        end else begin
            ph = PH_OPEN;
            np = pos;
        end
        return {ph, np};
    endfunction

    function automatic logic [PH_W-1:0] f_halt(input logic [PH_W-1:0] ph);
        return (ph == PH_CLOSING || ph == PH_OPENING) ? PH_STOPPED : ph;
    endfunction

    always_comb begin
        n_pos = r_pos;
        n_ph  = r_ph;
        w_res = '0;

        // Door and latches move one at a time, in sequence.
        if (i_step.door_en && (i_step.door_close || i_step.door_open)) begin
            if (i_step.door_close) begin
                if (r_ph[SLOT_DOOR] != PH_CLOSED) begin
                    w_res = f_close(r_pos[SLOT_DOOR], i_step.da_door);
                    {n_ph[SLOT_DOOR], n_pos[SLOT_DOOR]} = w_res;
                end else if (r_ph[SLOT_LATCHA] != PH_CLOSED) begin
                    w_res = f_close(r_pos[SLOT_LATCHA], i_step.da_dlatch);
                    {n_ph[SLOT_LATCHA], n_pos[SLOT_LATCHA]} = w_res;
                end else begin
                    w_res = f_close(r_pos[SLOT_LATCHB], i_step.da_dlatch);
                    {n_ph[SLOT_LATCHB], n_pos[SLOT_LATCHB]} = w_res;
                end
            end else begin
                if (r_ph[SLOT_LATCHB] != PH_OPEN) begin
                    w_res = f_open(r_pos[SLOT_LATCHB], i_step.da_dlatch);
                    {n_ph[SLOT_LATCHB], n_pos[SLOT_LATCHB]} = w_res;
                end else if (r_ph[SLOT_LATCHA] != PH_OPEN) begin
                    w_res = f_open(r_pos[SLOT_LATCHA], i_step.da_dlatch);
                    {n_ph[SLOT_LATCHA], n_pos[SLOT_LATCHA]} = w_res;
                end else begin
                    w_res = f_open(r_pos[SLOT_DOOR], i_step.da_door);
                    {n_ph[SLOT_DOOR], n_pos[SLOT_DOOR]} = w_res;
                end
            end
        end else begin
            n_ph[SLOT_DOOR]   = f_halt(r_ph[SLOT_DOOR]);
            n_ph[SLOT_LATCHA] = f_halt(r_ph[SLOT_LATCHA]);
            n_ph[SLOT_LATCHB] = f_halt(r_ph[SLOT_LATCHB]);
        end

        // The radiator sees the door and radiator latch phases of this same tick.
        if (i_step.power_ok) begin
            if (i_step.rl_close) begin
                {n_ph[SLOT_RLATCH], n_pos[SLOT_RLATCH]} =
                    f_close(r_pos[SLOT_RLATCH], i_step.da_rlatch);
            end else if (i_step.rl_open) begin
                {n_ph[SLOT_RLATCH], n_pos[SLOT_RLATCH]} =
                    f_open(r_pos[SLOT_RLATCH], i_step.da_rlatch);
            end else begin
                n_ph[SLOT_RLATCH] = f_halt(r_ph[SLOT_RLATCH]);
            end

            if (i_step.rad_stow && n_ph[SLOT_DOOR] == PH_OPEN) begin
                {n_ph[SLOT_RAD], n_pos[SLOT_RAD]} = f_close(r_pos[SLOT_RAD], i_step.da_rad);
            end else if (i_step.rad_deploy && n_ph[SLOT_DOOR] == PH_OPEN
                         && n_ph[SLOT_RLATCH] == PH_OPEN) begin
                {n_ph[SLOT_RAD], n_pos[SLOT_RAD]} = f_open(r_pos[SLOT_RAD], i_step.da_rad);
            end else begin
                n_ph[SLOT_RAD] = f_halt(r_ph[SLOT_RAD]);
            end
        end else begin
            n_ph[SLOT_RLATCH] = f_halt(r_ph[SLOT_RLATCH]);
            n_ph[SLOT_RAD]    = f_halt(r_ph[SLOT_RAD]);
        end

        if (i_step.power_ok && n_ph[SLOT_DOOR] == PH_OPEN && i_step.ant_stow) begin
            {n_ph[SLOT_ANT], n_pos[SLOT_ANT]} = f_close(r_pos[SLOT_ANT], i_step.da_ant);
        end else if (i_step.power_ok && n_ph[SLOT_DOOR] == PH_OPEN
                     && i_step.ant_deploy) begin
            {n_ph[SLOT_ANT], n_pos[SLOT_ANT]} = f_open(r_pos[SLOT_ANT], i_step.da_ant);
        end else begin
            n_ph[SLOT_ANT] = f_halt(r_ph[SLOT_ANT]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_POS; k++) begin
                r_pos[k] <= '0;
                r_ph[k]  <= PH_CLOSED;
            end
        end else if (i_adv) begin
            r_pos <= n_pos;
            r_ph  <= n_ph;
        end
    end

    // The state registers hold the last result; scale positions to 16 bits.
    for (genvar g = 0; g < NUM_POS; g++) begin : g_scale
        if (POS_BITS >= OUT_W) begin : g_down
            assign o_pos16[g] = r_pos[g][POS_BITS-1 -: OUT_W];
        end else begin : g_up
            assign o_pos16[g] = {r_pos[g], {(OUT_W-POS_BITS){1'b0}}};
        end
    end

    always_comb begin
        o_talkbacks = '0;
        o_talkbacks[TB_DOOR_OPEN]     = (r_ph[SLOT_DOOR] == PH_OPEN);
        o_talkbacks[TB_DOOR_CLOSED]   = (r_ph[SLOT_DOOR] == PH_CLOSED);
        o_talkbacks[TB_LATCH_LATCHED] = (r_ph[SLOT_RLATCH] == PH_CLOSED);
        o_talkbacks[TB_LATCH_RELEASE] = (r_ph[SLOT_RLATCH] == PH_OPEN);
        o_talkbacks[TB_RAD_STOWED]    = (r_ph[SLOT_RAD] == PH_CLOSED);
        o_talkbacks[TB_RAD_DEPLOYED]  = (r_ph[SLOT_RAD] == PH_OPEN);
        o_talkbacks[TB_ANT_STOWED]    = i_has_antenna && (r_ph[SLOT_ANT] == PH_CLOSED);
        o_talkbacks[TB_ANT_DEPLOYED]  = i_has_antenna && (r_ph[SLOT_ANT] == PH_OPEN);
    end

endmodule

>>> hw/rtl/interlocked_actuator_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interlocked_actuator_sequencer_top
// Moves door, door latches, radiator latch, radiator and antenna per tick item.
// ----------------------------------------------------------------------------
// Each input item is one time tick of commands; each produces one result item
// with six 16-bit positions and the talkback byte. From acceptance, an item
// passes through the input register, which forms the step sizes
// (tick length times speed), and then the actuator state registers, which also
// hold the result. One item is accepted per cycle as long as the output side
// keeps taking results. Speeds and the antenna-fitted flag must be written
// through the configuration port only while no item is in flight; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module interlocked_actuator_sequencer_top import iasq_pkg::*; #(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [DT_W-1:0]      i_delta_t,
    input  logic [1:0]           i_door_enable,
    input  logic                 i_door_close,
    input  logic                 i_door_open,
    input  logic [1:0]           i_mech_power,
    input  logic [1:0]           i_latch_cmd,
    input  logic [1:0]           i_release_cmd,
    input  logic [1:0]           i_stow_cmd,
    input  logic [1:0]           i_deploy_cmd,
    input  logic [1:0]           i_ku_stow,
    input  logic                 i_ku_deploy,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [OUT_W-1:0]     o_door_position,
    output logic [OUT_W-1:0]     o_latch_a_position,
    output logic [OUT_W-1:0]     o_latch_b_position,
    output logic [OUT_W-1:0]     o_rad_latch_position,
    output logic [OUT_W-1:0]     o_radiator_position,
    output logic [OUT_W-1:0]     o_antenna_position,
    output logic [TB_W-1:0]      o_talkbacks
);

    logic [SPEED_W-1:0] r_door_speed;
    logic [SPEED_W-1:0] r_door_latch_speed;
    logic [SPEED_W-1:0] r_rad_latch_speed;
    logic [SPEED_W-1:0] r_radiator_speed;
    logic [SPEED_W-1:0] r_antenna_speed;
    logic               r_has_antenna;

    logic               r_s1_vld;
    logic               r_out_vld;
    logic               w_adv;
    logic               w_in_acc;
    t_step              w_step;
    logic [OUT_W-1:0]   w_pos16 [NUM_POS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_door_speed       <= '0;
            r_door_latch_speed <= '0;
            r_rad_latch_speed  <= '0;
            r_radiator_speed   <= '0;
            r_antenna_speed    <= '0;
            r_has_antenna      <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DOOR_SPEED:       r_door_speed       <= i_cfg_data;
                CFG_DOOR_LATCH_SPEED: r_door_latch_speed <= i_cfg_data;
                CFG_RAD_LATCH_SPEED:  r_rad_latch_speed  <= i_cfg_data;
                CFG_RADIATOR_SPEED:   r_radiator_speed   <= i_cfg_data;
                CFG_ANTENNA_SPEED:    r_antenna_speed    <= i_cfg_data;
                CFG_HAS_ANTENNA:      r_has_antenna      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The state moves forward only when the result slot is free or being taken.
    assign w_adv      = r_s1_vld & (~r_out_vld | ~i_out_stall);
    assign o_in_stall = r_s1_vld & ~w_adv;
    assign w_in_acc   = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= w_in_acc | (r_s1_vld & ~w_adv);
            r_out_vld <= w_adv | (r_out_vld & i_out_stall);
        end
    end

    iasq_input_stage u_input (
        .i_clk              (i_clk),
        .i_load             (w_in_acc),
        .i_delta_t          (i_delta_t),
        .i_door_enable      (i_door_enable),
        .i_door_close       (i_door_close),
        .i_door_open        (i_door_open),
        .i_mech_power       (i_mech_power),
        .i_latch_cmd        (i_latch_cmd),
        .i_release_cmd      (i_release_cmd),
        .i_stow_cmd         (i_stow_cmd),
        .i_deploy_cmd       (i_deploy_cmd),
        .i_ku_stow          (i_ku_stow),
        .i_ku_deploy        (i_ku_deploy),
        .i_door_speed       (r_door_speed),
        .i_door_latch_speed (r_door_latch_speed),
        .i_rad_latch_speed  (r_rad_latch_speed),
        .i_radiator_speed   (r_radiator_speed),
        .i_antenna_speed    (r_antenna_speed),
        .o_step             (w_step)
    );

    iasq_motion_core #(
        .POS_BITS (POS_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv),
        .i_step        (w_step),
        .i_has_antenna (r_has_antenna),
        .o_pos16       (w_pos16),
        .o_talkbacks   (o_talkbacks)
    );

    assign o_out_valid          = r_out_vld;
    assign o_door_position      = w_pos16[SLOT_DOOR];
    assign o_latch_a_position   = w_pos16[SLOT_LATCHA];
    assign o_latch_b_position   = w_pos16[SLOT_LATCHB];
    assign o_rad_latch_position = w_pos16[SLOT_RLATCH];
    assign o_radiator_position  = w_pos16[SLOT_RAD];
    assign o_antenna_position   = w_pos16[SLOT_ANT];

endmodule
